FILE: src/tfg_pkg.sv
// Shared types, constants and codes of the two-finger gesture recognizer.
`timescale 1ns / 1ps

package tfg_pkg;

    // Field and register widths
    localparam int COORD_W    = 16;
    localparam int TIMER_W    = 16;
    localparam int DPI_W      = 10;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 1;

    // Queue between classifier and executor
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // 3 mm test: (dx^2 + dy^2) * 64516 >= 900 * dpi^2
    localparam int SCALE_W  = 16;
    localparam int DPIK_W   = 10;
    localparam int SQ_W     = 2 * COORD_W + 1;
    localparam int LHS_W    = SQ_W + SCALE_W;
    localparam int DPI2_W   = 2 * DPI_W;
    localparam int RHS_W    = DPI2_W + DPIK_W;
    localparam logic [SCALE_W-1:0] DIST_SCALE = SCALE_W'(64516);
    localparam logic [DPIK_W-1:0]  DPI_SCALE  = DPIK_W'(900);

    // Register indexes and reset values
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_DPI = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_CLICK_TIME = 1'b1;
    localparam logic [DPI_W-1:0]     DPI_RESET      = DPI_W'(96);
    localparam logic [TIMER_W-1:0]   CLICK_RESET    = TIMER_W'(750);

    typedef logic signed [COORD_W-1:0] t_coord;

    typedef enum logic [2:0] {
        OP_PRESS   = 3'd0,
        OP_RELEASE = 3'd1,
        OP_MOVE    = 3'd2,
        OP_CANCEL  = 3'd3,
        OP_TICK    = 3'd4
    } t_op;

    typedef enum logic [2:0] {
        EV_CLICK      = 3'd0,
        EV_DRAG_START = 3'd1,
        EV_DRAG       = 3'd2,
        EV_ZOOM_START = 3'd3,
        EV_ZOOM       = 3'd4
    } t_kind;

    typedef struct packed {
        t_op    op;
        logic   finger;
        t_coord x;
        t_coord y;
    } t_item;

    typedef struct packed {
        t_kind  kind;
        t_coord first_x;
        t_coord first_y;
        t_coord second_x;
        t_coord second_y;
        logic   may_be_click;
        logic   last_of_run;
    } t_result;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SQX,
        ST_SQY,
        ST_SCALE,
        ST_CMP,
        ST_EMIT
    } t_back_state;

endpackage

FILE: src/tfg_front.sv
// Input stage: registers a touch word, drops unused opcodes, feeds the queue.
`timescale 1ns / 1ps

module tfg_front (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [2:0]                          i_opcode,
    input  logic                                i_finger_index,
    input  logic signed [tfg_pkg::COORD_W-1:0] i_pos_x,
    input  logic signed [tfg_pkg::COORD_W-1:0] i_pos_y,
    output logic                                o_push,
    output tfg_pkg::t_item                      o_item,
    input  logic                                i_q_ready
);

    logic           r_valid;
    logic           r_ok;
    tfg_pkg::t_item r_item;
    logic           n_ok;
    logic           w_take;

    // opcode classification
    always_comb begin
        unique case (i_opcode)
            tfg_pkg::OP_PRESS, tfg_pkg::OP_RELEASE, tfg_pkg::OP_MOVE,
            tfg_pkg::OP_CANCEL, tfg_pkg::OP_TICK: begin
                n_ok = 1'b1;
            end
            default: begin
                n_ok = 1'b0;
            end
        endcase
    end

    // register frees when empty, when it holds a dropped word, or on push
    assign o_in_ready = !r_valid || !r_ok || i_q_ready;
    assign w_take     = i_in_valid && o_in_ready;
    assign o_push     = r_valid && r_ok;
    assign o_item     = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_ok          <= n_ok;
            r_item.op     <= tfg_pkg::t_op'(i_opcode);
            r_item.finger <= i_finger_index;
            r_item.x      <= i_pos_x;
            r_item.y      <= i_pos_y;
        end
    end

endmodule

FILE: src/tfg_queue.sv
// Small register queue between the classifier and the executor.
`timescale 1ns / 1ps

module tfg_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  tfg_pkg::t_item i_item,
    output logic           o_ready,
    input  logic           i_pop,
    output logic           o_valid,
    output tfg_pkg::t_item o_item
);

    tfg_pkg::t_item                  r_mem [tfg_pkg::QUEUE_DEPTH];
    logic [tfg_pkg::QPTR_W-1:0]      r_wp;
    logic [tfg_pkg::QPTR_W-1:0]      r_rp;
    logic [tfg_pkg::QCNT_W-1:0]      r_cnt;
    logic                            w_wr;
    logic                            w_rd;

    assign o_ready = (r_cnt != tfg_pkg::QCNT_W'(tfg_pkg::QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_item  = r_mem[r_rp];
    assign w_wr    = i_push && o_ready;
    assign w_rd    = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_wr) begin
                r_wp <= (r_wp == tfg_pkg::QPTR_W'(tfg_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                              : r_wp + 1'b1;
            end
            if (w_rd) begin
                r_rp <= (r_rp == tfg_pkg::QPTR_W'(tfg_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                              : r_rp + 1'b1;
            end
            if (w_wr && !w_rd) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!w_wr && w_rd) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wp] <= i_item;
        end
    end

`ifndef SYNTHESIS
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= tfg_pkg::QCNT_W'(tfg_pkg::QUEUE_DEPTH))
        else $error("queue count out of range");
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == '0) |-> (r_wp == r_rp))
        else $error("empty queue with unequal pointers");
    a_full_ptrs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_wr && !w_rd) |=> (r_cnt == $past(r_cnt) + 1'b1))
        else $error("push lost");
`endif

endmodule

FILE: src/tfg_back.sv
// Executor: finger state, click timer, 3 mm test and result sequencing.
`timescale 1ns / 1ps

module tfg_back (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_q_valid,
    input  tfg_pkg::t_item                     i_q_item,
    output logic                               o_q_pop,
    input  logic [tfg_pkg::DPI_W-1:0]          i_screen_dpi,
    input  logic [tfg_pkg::TIMER_W-1:0]        i_click_ticks,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output tfg_pkg::t_result                   o_out
);

    tfg_pkg::t_back_state            r_state, n_state;
    tfg_pkg::t_item                  r_item, n_item;
    logic [1:0]                      r_mask, n_mask;
    logic                            r_pend, n_pend;
    logic [tfg_pkg::TIMER_W-1:0]     r_timer, n_timer;
    tfg_pkg::t_coord                 r_start_x [2];
    tfg_pkg::t_coord                 r_start_y [2];
    tfg_pkg::t_coord                 r_last_x  [2];
    tfg_pkg::t_coord                 r_last_y  [2];
    tfg_pkg::t_coord                 n_start_x [2];
    tfg_pkg::t_coord                 n_start_y [2];
    tfg_pkg::t_coord                 n_last_x  [2];
    tfg_pkg::t_coord                 n_last_y  [2];
    tfg_pkg::t_result                r_res [2];
    tfg_pkg::t_result                n_res [2];
    logic [1:0]                      r_cnt, n_cnt;
    logic                            r_idx, n_idx;
    tfg_pkg::t_result                r_out, n_out;
    logic                            r_out_valid, n_out_valid;

    // distance datapath
    logic [tfg_pkg::SQ_W-1:0]        r_acc;
    logic [tfg_pkg::LHS_W-1:0]       r_lhs;
    logic [tfg_pkg::DPI2_W-1:0]      r_dpi2;
    logic [tfg_pkg::RHS_W-1:0]       r_rhs;
    logic signed [tfg_pkg::COORD_W:0]   w_dx;
    logic signed [tfg_pkg::COORD_W:0]   w_dy;
    logic signed [tfg_pkg::SQ_W:0]      w_sqx;
    logic signed [tfg_pkg::SQ_W:0]      w_sqy;
    logic                            w_far;
    logic [1:0]                      w_bit;

    // One result chosen by the press mask; an empty mask gives a zeroed result of the first kind.
    function automatic tfg_pkg::t_result mk_res(
        input logic [1:0]       mask,
        input tfg_pkg::t_coord  x0,
        input tfg_pkg::t_coord  y0,
        input tfg_pkg::t_coord  x1,
        input tfg_pkg::t_coord  y1,
        input logic             pend,
        input tfg_pkg::t_kind   k_one,
        input tfg_pkg::t_kind   k_two
    );
        tfg_pkg::t_result r;
        r              = '0;
        r.kind         = k_one;
        unique case (mask)
            2'b01: begin
                r.first_x      = x0;
                r.first_y      = y0;
                r.may_be_click = pend;
            end
            2'b10: begin
                r.first_x      = x1;
                r.first_y      = y1;
                r.may_be_click = pend;
            end
            2'b11: begin
                r.kind     = k_two;
                r.first_x  = x0;
                r.first_y  = y0;
                r.second_x = x1;
                r.second_y = y1;
            end
            default: begin
                r.may_be_click = 1'b0;
            end
        endcase
        return r;
    endfunction

    assign w_dx  = {r_last_x[0][tfg_pkg::COORD_W-1], r_last_x[0]}
                 - {r_start_x[0][tfg_pkg::COORD_W-1], r_start_x[0]};
    assign w_dy  = {r_last_y[0][tfg_pkg::COORD_W-1], r_last_y[0]}
                 - {r_start_y[0][tfg_pkg::COORD_W-1], r_start_y[0]};
    assign w_sqx = w_dx * w_dx;
    assign w_sqy = w_dy * w_dy;
    assign w_far = (r_lhs >= tfg_pkg::LHS_W'(r_rhs));
    assign w_bit = r_item.finger ? 2'b10 : 2'b01;

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    always_comb begin
        n_state     = r_state;
        n_item      = r_item;
        n_mask      = r_mask;
        n_pend      = r_pend;
        n_timer     = r_timer;
        n_start_x   = r_start_x;
        n_start_y   = r_start_y;
        n_last_x    = r_last_x;
        n_last_y    = r_last_y;
        n_res       = r_res;
        n_cnt       = r_cnt;
        n_idx       = r_idx;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_out_ready;
        o_q_pop     = 1'b0;

        unique case (r_state)
            tfg_pkg::ST_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    n_item  = i_q_item;
                    n_state = tfg_pkg::ST_EXEC;
                end
            end
            tfg_pkg::ST_EXEC: begin
                n_cnt   = 2'd0;
                n_idx   = 1'b0;
                n_state = tfg_pkg::ST_IDLE;
                unique case (r_item.op)
                    tfg_pkg::OP_PRESS: begin
                        n_pend = 1'b0;
                        if (r_mask == 2'b00 && !r_item.finger) begin
                            n_pend  = 1'b1;
                            n_timer = i_click_ticks;
                        end
                        n_last_x[r_item.finger] = r_item.x;
                        n_last_y[r_item.finger] = r_item.y;
                        n_mask    = r_mask | w_bit;
                        n_start_x = n_last_x;
                        n_start_y = n_last_y;
                        n_res[0]  = mk_res(n_mask, n_last_x[0], n_last_y[0],
                                           n_last_x[1], n_last_y[1], n_pend,
                                           tfg_pkg::EV_DRAG_START,
                                           tfg_pkg::EV_ZOOM_START);
                        n_cnt     = 2'd1;
                    end
                    tfg_pkg::OP_RELEASE: begin
                        n_mask    = r_mask & ~w_bit;
                        n_start_x = r_last_x;
                        n_start_y = r_last_y;
                        n_res[0]  = mk_res(n_mask, r_last_x[0], r_last_y[0],
                                           r_last_x[1], r_last_y[1], r_pend,
                                           tfg_pkg::EV_DRAG_START,
                                           tfg_pkg::EV_ZOOM_START);
                        if (n_mask != 2'b00) begin
                            n_cnt = 2'd1;
                        end else if (r_pend) begin
                            // lone click at finger 0
                            n_res[0]      = '0;
                            n_res[0].kind = tfg_pkg::EV_CLICK;
                            n_res[0].first_x = r_last_x[0];
                            n_res[0].first_y = r_last_y[0];
                            n_cnt         = 2'd1;
                        end
                        n_pend = 1'b0;
                    end
                    tfg_pkg::OP_MOVE: begin
                        n_last_x[r_item.finger] = r_item.x;
                        n_last_y[r_item.finger] = r_item.y;
                        if (r_pend && !r_item.finger) begin
                            n_state = tfg_pkg::ST_SQX;
                        end else begin
                            n_res[0] = mk_res(r_mask, n_last_x[0], n_last_y[0],
                                              n_last_x[1], n_last_y[1], r_pend,
                                              tfg_pkg::EV_DRAG, tfg_pkg::EV_ZOOM);
                            n_cnt    = (r_mask != 2'b00) ? 2'd1 : 2'd0;
                        end
                    end
                    tfg_pkg::OP_CANCEL: begin
                        n_mask = 2'b00;
                        n_pend = 1'b0;
                    end
                    tfg_pkg::OP_TICK: begin
                        if (r_pend) begin
                            if (r_timer <= tfg_pkg::TIMER_W'(1)) begin
                                // candidate expired: becomes a plain drag
                                n_timer          = '0;
                                n_pend           = 1'b0;
                                n_res[0]         = '0;
                                n_res[0].kind    = tfg_pkg::EV_DRAG;
                                n_res[0].first_x = r_last_x[0];
                                n_res[0].first_y = r_last_y[0];
                                n_cnt            = 2'd1;
                            end else begin
                                n_timer = r_timer - 1'b1;
                            end
                        end
                    end
                    default: begin
                        n_cnt = 2'd0;
                    end
                endcase
                if (n_state == tfg_pkg::ST_IDLE && n_cnt != 2'd0) begin
                    n_state = tfg_pkg::ST_EMIT;
                end
            end
            tfg_pkg::ST_SQX: begin
                n_state = tfg_pkg::ST_SQY;
            end
            tfg_pkg::ST_SQY: begin
                n_state = tfg_pkg::ST_SCALE;
            end
            tfg_pkg::ST_SCALE: begin
                n_state = tfg_pkg::ST_CMP;
            end
            tfg_pkg::ST_CMP: begin
                n_pend   = r_pend && !w_far;
                n_res[0] = mk_res(r_mask, r_last_x[0], r_last_y[0],
                                  r_last_x[1], r_last_y[1], n_pend,
                                  tfg_pkg::EV_DRAG, tfg_pkg::EV_ZOOM);
                n_idx    = 1'b0;
                if (r_mask != 2'b00) begin
                    n_cnt   = 2'd1;
                    n_state = tfg_pkg::ST_EMIT;
                end else begin
                    n_cnt   = 2'd0;
                    n_state = tfg_pkg::ST_IDLE;
                end
            end
            tfg_pkg::ST_EMIT: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out             = r_res[r_idx];
                    n_out.last_of_run = ({1'b0, r_idx} == r_cnt - 2'd1);
                    n_out_valid       = 1'b1;
                    if (n_out.last_of_run) begin
                        n_state = tfg_pkg::ST_IDLE;
                    end else begin
                        n_idx = 1'b1;
                    end
                end
            end
            default: begin
                n_state = tfg_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tfg_pkg::ST_IDLE;
            r_mask      <= 2'b00;
            r_pend      <= 1'b0;
            r_timer     <= '0;
            r_start_x   <= '{default: '0};
            r_start_y   <= '{default: '0};
            r_last_x    <= '{default: '0};
            r_last_y    <= '{default: '0};
            r_cnt       <= 2'd0;
            r_idx       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_mask      <= n_mask;
            r_pend      <= n_pend;
            r_timer     <= n_timer;
            r_start_x   <= n_start_x;
            r_start_y   <= n_start_y;
            r_last_x    <= n_last_x;
            r_last_y    <= n_last_y;
            r_cnt       <= n_cnt;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item <= n_item;
        r_res  <= n_res;
        r_out  <= n_out;
        unique case (r_state)
            tfg_pkg::ST_SQX: begin
                r_acc  <= w_sqx[tfg_pkg::SQ_W-1:0];
                r_dpi2 <= i_screen_dpi * i_screen_dpi;
            end
            tfg_pkg::ST_SQY: begin
                r_acc <= r_acc + w_sqy[tfg_pkg::SQ_W-1:0];
                r_rhs <= r_dpi2 * tfg_pkg::DPI_SCALE;
            end
            tfg_pkg::ST_SCALE: begin
                r_lhs <= r_acc * tfg_pkg::DIST_SCALE;
            end
            default: begin
                r_acc <= r_acc;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_pend_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> (r_mask == 2'b01))
        else $error("click candidate armed without finger 0 alone");
    a_emit_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tfg_pkg::ST_EMIT) |-> (r_cnt != 2'd0 && {1'b0, r_idx} < r_cnt))
        else $error("emit index beyond result count");
    a_test_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tfg_pkg::ST_SQX) |->
            (r_pend && !r_item.finger && r_item.op == tfg_pkg::OP_MOVE))
        else $error("distance test started without an armed finger 0 move");
    a_test_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tfg_pkg::ST_SQX) |=> (r_state == tfg_pkg::ST_SQY))
        else $error("distance sequence broken");
`endif

endmodule

FILE: src/two_finger_gesture_recognizer.sv
// Top level of the two-finger gesture recognizer: config registers and wiring.
`timescale 1ns / 1ps

// Usage:
//  - Input channel (i_in_valid / o_in_ready): one touch word per handshake,
//    opcode press, release, move, cancel or tick, with finger index and x, y.
//    Words with opcodes five to seven are accepted and dropped.
//  - Output channel (o_out_valid / i_out_ready): click, drag start, drag,
//    zoom start and zoom words. A touch word yields zero or one result
//    word; o_last_of_run is set on every result word.
//  - Config port (i_cfg_we, i_cfg_index, i_cfg_data): index 0 screen dpi,
//    index 1 click time in ticks. Write only while the block is idle.
//  - Path: front register, queue, executor, output register; a finger 0 move
//    with a click candidate armed adds the 3 mm distance test (two squares,
//    scale, compare).
//  - Flow: the executor handles one word at a time and pops the next only
//    once back in idle, after any result is emitted. The classifier and
//    the two-word queue keep accepting words while the executor is busy.
//  - Reset (synchronous, active low) clears the finger state, the candidate
//    and timer, and sets dpi 96 and click time 750; no clearing pass.
//  - When the receiver stalls, the output register holds its word; the queue
//    fills and then o_in_ready drops.

module two_finger_gesture_recognizer (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    // touch words in
    input  logic                                    i_in_valid,
    output logic                                    o_in_ready,
    input  logic [2:0]                              i_opcode,
    input  logic                                    i_finger_index,
    input  logic signed [tfg_pkg::COORD_W-1:0]     i_pos_x,
    input  logic signed [tfg_pkg::COORD_W-1:0]     i_pos_y,
    // gesture words out
    output logic                                    o_out_valid,
    input  logic                                    i_out_ready,
    output logic [2:0]                              o_event_kind,
    output logic signed [tfg_pkg::COORD_W-1:0]     o_first_x,
    output logic signed [tfg_pkg::COORD_W-1:0]     o_first_y,
    output logic signed [tfg_pkg::COORD_W-1:0]     o_second_x,
    output logic signed [tfg_pkg::COORD_W-1:0]     o_second_y,
    output logic                                    o_may_be_click,
    output logic                                    o_last_of_run,
    // configuration writes
    input  logic                                    i_cfg_we,
    input  logic [tfg_pkg::CFG_IDX_W-1:0]           i_cfg_index,
    input  logic [tfg_pkg::CFG_DATA_W-1:0]          i_cfg_data
);

    logic [tfg_pkg::DPI_W-1:0]   r_screen_dpi;
    logic [tfg_pkg::TIMER_W-1:0] r_click_ticks;

    logic             w_push;
    tfg_pkg::t_item   w_front_item;
    logic             w_q_ready;
    logic             w_q_valid;
    logic             w_q_pop;
    tfg_pkg::t_item   w_q_item;
    tfg_pkg::t_result w_out;

    // Config registers: plain write, no read-back.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_screen_dpi  <= tfg_pkg::DPI_RESET;
            r_click_ticks <= tfg_pkg::CLICK_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                tfg_pkg::CFG_SCREEN_DPI: begin
                    r_screen_dpi <= i_cfg_data[tfg_pkg::DPI_W-1:0];
                end
                tfg_pkg::CFG_CLICK_TIME: begin
                    r_click_ticks <= i_cfg_data[tfg_pkg::TIMER_W-1:0];
                end
                default: begin
                    r_screen_dpi <= r_screen_dpi;
                end
            endcase
        end
    end

    // Front: registers and classifies touch words.
    tfg_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_opcode       (i_opcode),
        .i_finger_index (i_finger_index),
        .i_pos_x        (i_pos_x),
        .i_pos_y        (i_pos_y),
        .o_push         (w_push),
        .o_item         (w_front_item),
        .i_q_ready      (w_q_ready)
    );

    // Decoupling queue.
    tfg_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_front_item),
        .o_ready (w_q_ready),
        .i_pop   (w_q_pop),
        .o_valid (w_q_valid),
        .o_item  (w_q_item)
    );

    // Back: gesture state, timer, distance test and output register.
    tfg_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (w_q_valid),
        .i_q_item      (w_q_item),
        .o_q_pop       (w_q_pop),
        .i_screen_dpi  (r_screen_dpi),
        .i_click_ticks (r_click_ticks),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_out         (w_out)
    );

    assign o_event_kind   = w_out.kind;
    assign o_first_x      = w_out.first_x;
    assign o_first_y      = w_out.first_y;
    assign o_second_x     = w_out.second_x;
    assign o_second_y     = w_out.second_y;
    assign o_may_be_click = w_out.may_be_click;
    assign o_last_of_run  = w_out.last_of_run;

endmodule
